// File: hdl/multilevel_feedback_scheduler_top_assert.svh
// assertion macros for the multilevel feedback scheduler
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_TOP_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_TOP_ASSERT_SVH
`ifndef SYNTH
`define MFS_ASSERT_IMPL(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define MFS_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define MFS_ASSERT_IMPL(label, clk, rst, cond, msg)
`define MFS_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

// File: hdl/mfs_pkg.sv
// shared constants and types for the multilevel feedback scheduler
package mfs_pkg;
  localparam int LEVELS = 5;
  localparam int CAPACITY = 64;
  localparam int TIME_BITS = 16;
  localparam int NQUEUES = LEVELS + 1;
  localparam int ARRIVAL = LEVELS;
  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int Q_W = $clog2(NQUEUES);

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_ORDER    = 3'd2;
  localparam logic [2:0] ST_BAD      = 3'd3;
  localparam logic [2:0] ST_IDLE     = 3'd4;
  localparam logic [2:0] ST_RAN      = 3'd5;
  localparam logic [2:0] ST_DONE     = 3'd6;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [TIME_BITS-1:0] time_t;

  // one process record
  typedef struct packed {
    logic [7:0] id;
    logic [2:0] level;
    time_t      start;
    logic [15:0] run;
    logic [15:0] used;
  } rec_t;

  // request from control to the record memory
  typedef struct packed {
    logic  rd;
    slot_t rd_addr;
    logic  wr;
    slot_t wr_addr;
    rec_t  wr_data;
    logic  lk_wr;
    slot_t lk_addr;
    slot_t lk_data;
  } mem_req_t;
endpackage

// File: hdl/mfs_store.sv
// record and link memories, registered read
module mfs_store (
  input  logic              clk,
  input  mfs_pkg::mem_req_t req,
  output mfs_pkg::rec_t     rd_rec,
  output mfs_pkg::slot_t    rd_link
);
  import mfs_pkg::*;

  rec_t  rec_mem [CAPACITY];
  slot_t link_mem [CAPACITY];

  // record array
  always_ff @(posedge clk) begin
    if (req.wr) rec_mem[req.wr_addr] <= req.wr_data;
    if (req.rd) rd_rec <= rec_mem[req.rd_addr];
  end

  // link array
  always_ff @(posedge clk) begin
    if (req.lk_wr) link_mem[req.lk_addr] <= req.lk_data;
    if (req.rd) rd_link <= link_mem[req.rd_addr];
  end
endmodule

// File: hdl/mfs_ctrl.sv
// sequencer: submit, admission loop, run and relink
module mfs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              req_type,
  input  logic [2:0]        priority_req,
  input  logic [15:0]       start_tick,
  input  logic [15:0]       run_quanta,
  output logic              busy,
  output logic              done,
  output logic [2:0]        status,
  output logic [7:0]        process_id,
  output logic [2:0]        run_level,
  output logic [2:0]        next_level,
  output logic [15:0]       time_now,
  output logic              pending,
  output mfs_pkg::mem_req_t req,
  input  mfs_pkg::rec_t     rd_rec,
  input  mfs_pkg::slot_t    rd_link
);
  import mfs_pkg::*;
  `include "multilevel_feedback_scheduler_top_assert.svh"

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ARD  = 3'd1;
  localparam logic [2:0] S_ACHK = 3'd2;
  localparam logic [2:0] S_PICK = 3'd3;
  localparam logic [2:0] S_RCHK = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state;
  slot_t qhead [NQUEUES];
  slot_t qtail [NQUEUES];
  logic [NQUEUES-1:0] qne;
  slot_t free_slots [CAPACITY];
  slot_t free_top;
  slot_t free_rd_addr;
  logic rel_en;
  logic [CNT_W-1:0] free_count;
  logic [CNT_W-1:0] init_cnt;
  time_t tick_count, last_start;
  logic [7:0] next_seq;
  logic [Q_W-1:0] run_q;
  slot_t cur;

  // push/pop helper signals, at most one pop and one push per cycle
  logic push_en, pop_en;
  logic [Q_W-1:0] push_q, pop_q;
  slot_t push_s;
  logic link_fix;
  logic sub_ok;

  logic [NQUEUES-1:0] qne_next;
  logic found;
  logic [Q_W-1:0] low_q;
  logic [15:0] used_inc;

  // lowest non-empty level
  always_comb begin
    found = 1'b0;
    low_q = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (qne[i]) begin
        found = 1'b1;
        low_q = Q_W'(i);
      end
    end
  end

  assign used_inc = rd_rec.used + 16'd1;
  assign busy = (state != S_IDLE) || (init_cnt != CNT_W'(CAPACITY));
  assign pending = |qne;

  // submit that passes every check
  assign sub_ok = start && !busy && !req_type && priority_req < 3'(LEVELS)
                  && run_quanta != 16'd0 && start_tick >= last_start
                  && start_tick >= tick_count && free_count != '0;

  // queue control decode
  always_comb begin
    push_en = 1'b0; pop_en = 1'b0;
    push_q = '0; pop_q = '0; push_s = '0;
    req = '0;
    req.wr_data = rd_rec;
    unique case (state)
      S_IDLE: begin
        if (sub_ok) begin
          push_en = 1'b1;
          push_q = Q_W'(ARRIVAL);
          push_s = free_top;
          req.wr = 1'b1;
          req.wr_addr = push_s;
          req.wr_data.id = next_seq;
          req.wr_data.level = priority_req;
          req.wr_data.start = start_tick;
          req.wr_data.run = run_quanta;
          req.wr_data.used = '0;
        end
      end
      S_ARD: begin
        req.rd = 1'b1;
        req.rd_addr = qhead[ARRIVAL];
      end
      S_ACHK: begin
        if (qne[ARRIVAL] && rd_rec.start == tick_count) begin
          pop_en = 1'b1;
          pop_q = Q_W'(ARRIVAL);
          push_en = 1'b1;
          push_q = Q_W'(rd_rec.level);
          push_s = qhead[ARRIVAL];
        end
      end
      S_PICK: begin
        req.rd = found;
        req.rd_addr = qhead[low_q];
      end
      S_RCHK: begin
        pop_en = 1'b1;
        pop_q = run_q;
        req.wr = 1'b1;
        req.wr_addr = cur;
        req.wr_data.used = used_inc;
        if (used_inc < rd_rec.run) begin
          push_en = 1'b1;
          push_q = (run_q < Q_W'(LEVELS - 1)) ? run_q + 1'b1 : run_q;
          push_s = cur;
          req.wr_data.level = 3'(push_q);
        end
      end
      S_OUT: ;
      default: ;
    endcase
    // old tail links to the pushed slot when the queue stays non-empty
    link_fix = push_en && qne[push_q]
               && !(pop_en && pop_q == push_q && qhead[pop_q] == qtail[pop_q]);
    if (link_fix) begin
      req.lk_wr = 1'b1;
      req.lk_addr = qtail[push_q];
      req.lk_data = push_s;
    end
    qne_next = qne;
    if (pop_en && qhead[pop_q] == qtail[pop_q]) qne_next[pop_q] = 1'b0;
    if (push_en) qne_next[push_q] = 1'b1;
  end

  // free-slot stack, filled after reset with slot 0 on top
  assign rel_en = (state == S_RCHK) && !push_en;
  assign free_rd_addr = free_count[SLOT_W-1:0] - SLOT_W'(1);

  always_ff @(posedge clk) begin
    if (init_cnt != CNT_W'(CAPACITY)) begin
      free_slots[SLOT_W'(CAPACITY - 1) - init_cnt[SLOT_W-1:0]] <= init_cnt[SLOT_W-1:0];
    end else if (rel_en) begin
      free_slots[free_count[SLOT_W-1:0]] <= cur;
    end
    free_top <= free_slots[free_rd_addr];
  end

  // sequencing and queue registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      qne <= '0;
      free_count <= CNT_W'(CAPACITY);
      init_cnt <= '0;
      tick_count <= '0;
      last_start <= '0;
      next_seq <= '0;
      done <= 1'b0;
      for (int i = 0; i < NQUEUES; i++) begin
        qhead[i] <= '0;
        qtail[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      if (init_cnt != CNT_W'(CAPACITY)) begin
        init_cnt <= init_cnt + 1'b1;
      end
      qne <= qne_next;
      if (pop_en && qhead[pop_q] != qtail[pop_q]) qhead[pop_q] <= rd_link;
      if (push_en) begin
        qtail[push_q] <= push_s;
        if (!link_fix) qhead[push_q] <= push_s;
      end
      unique case (state)
        S_IDLE: begin
          if (start && !busy) begin
            time_now <= tick_count;
            process_id <= sub_ok ? next_seq : 8'd0;
            run_level <= '0; next_level <= '0;
            if (req_type) begin
              state <= S_ARD;
            end else begin
              state <= S_OUT;
              if (priority_req >= 3'(LEVELS) || run_quanta == 16'd0) status <= ST_BAD;
              else if (start_tick < last_start || start_tick < tick_count) status <= ST_ORDER;
              else if (free_count == '0) status <= ST_FULL;
              else begin
                status <= ST_ACCEPTED;
                free_count <= free_count - 1'b1;
                last_start <= start_tick;
                next_seq <= next_seq + 8'd1;
              end
            end
          end
        end
        S_ARD: state <= S_ACHK;
        S_ACHK: state <= pop_en ? S_ARD : S_PICK;
        S_PICK: begin
          run_q <= low_q;
          cur <= qhead[low_q];
          if (found) state <= S_RCHK;
          else begin
            status <= ST_IDLE;
            state <= S_OUT;
            if (tick_count != '1) tick_count <= tick_count + 1'b1;
          end
        end
        S_RCHK: begin
          process_id <= rd_rec.id;
          run_level <= 3'(run_q);
          if (tick_count != '1) tick_count <= tick_count + 1'b1;
          if (push_en) begin
            status <= ST_RAN;
            next_level <= 3'(push_q);
          end else begin
            status <= ST_DONE;
            free_count <= free_count + 1'b1;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MFS_ASSERT_IMPL(a_free_range, clk, rst, free_count <= CNT_W'(CAPACITY), "free count overflow")
  `MFS_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "done held two cycles")
  `MFS_ASSERT_IMPL(a_done_idle, clk, rst, !done || state == S_IDLE, "done outside idle")
  `MFS_ASSERT_IMPL(a_link_self, clk, rst, !req.lk_wr || req.lk_addr != req.lk_data, "self link")
endmodule

// File: hdl/multilevel_feedback_scheduler_top.sv
// Multilevel feedback scheduler top level.
// A submit goes straight to the result; a tick first admits every arrival due now (record read,
// then relink), then runs the head of the lowest non-empty level or reports idle.
// Throughput: one item at a time; busy drops in the done cycle, so the next item can start there.
// Synchronous reset; after reset busy stays high while the free list fills.
// Results appear for one cycle with done; the receiver cannot stall.
module multilevel_feedback_scheduler_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic        req_type,
  input  logic [2:0]  priority_req,
  input  logic [15:0] start_tick,
  input  logic [15:0] run_quanta,
  output logic [2:0]  status,
  output logic [7:0]  process_id,
  output logic [2:0]  run_level,
  output logic [2:0]  next_level,
  output logic [15:0] time_now,
  output logic        pending
);
  import mfs_pkg::*;

  mem_req_t req;
  rec_t     rd_rec;
  slot_t    rd_link;

  // control sequencer
  mfs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .req_type(req_type),
    .priority_req(priority_req), .start_tick(start_tick), .run_quanta(run_quanta),
    .busy(busy), .done(done), .status(status), .process_id(process_id),
    .run_level(run_level), .next_level(next_level), .time_now(time_now),
    .pending(pending), .req(req), .rd_rec(rd_rec), .rd_link(rd_link)
  );

  // record store
  mfs_store u_store (.clk(clk), .req(req), .rd_rec(rd_rec), .rd_link(rd_link));
endmodule
